FILE: sv/plcm_pkg.sv
// Shared types and constants for the piecewise-linear color map core.
// Holds the controller-to-datapath command and status structs.
// No dependencies.
package plcm_pkg;

    localparam int CH_NUM  = 4;   // red, green, blue, alpha
    localparam int CH_W    = 8;   // bits per color channel
    localparam int COLOR_W = CH_NUM * CH_W;
    localparam int SLOT_W  = 4;   // width of the slot field
    localparam int Q_W     = 8;   // quotient bits, one per divide step
    localparam int BIT_W   = 3;   // indexes one quotient bit

    typedef logic [CH_W-1:0] t_chan;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             capture;   // latch the sample of a map request
        logic             write;     // store a segment from the input fields
        logic             read;      // fetch the table entry at the search index
        logic             mul;       // form offset * color difference per channel
        logic             div_step;  // one restoring divide step on all channels
        logic [BIT_W-1:0] div_bit;   // quotient bit decided by this step
        logic             load_out;  // load the result register
        logic             out_hit;   // result is a hit, else zero color
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_valid;  // slot at the search index holds a segment
        logic in_range;    // fetched segment covers the sample
    } t_sts;

endpackage

FILE: sv/piecewise_linear_color_map_core.sv
// A write request is stored at its accept edge. A map request searches the empty and filled
// slots; a hit is followed by the multiply, the divide steps and the load, a miss by the load
// alone. A new map request is taken only after the previous one has finished; the pace is set
// by the single table read port and the bit-per-cycle divide, and a waiting result stalls the
// load cycle.
// Reset (synchronous, active low) clears the valid bits and the controller, not the tables.
module piecewise_linear_color_map_core #(
    parameter int SEGMENT_SLOTS = 16,
    parameter int SAMPLE_BITS   = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [plcm_pkg::SLOT_W-1:0]  i_slot,
    input  logic [SAMPLE_BITS-1:0]       i_start_index,
    input  logic [SAMPLE_BITS-1:0]       i_end_index,
    input  logic [plcm_pkg::COLOR_W-1:0] i_start_color,
    input  logic [plcm_pkg::COLOR_W-1:0] i_end_color,
    input  logic [SAMPLE_BITS-1:0]       i_datum,
    // Result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [plcm_pkg::CH_W-1:0]    o_red,
    output logic [plcm_pkg::CH_W-1:0]    o_green,
    output logic [plcm_pkg::CH_W-1:0]    o_blue,
    output logic [plcm_pkg::CH_W-1:0]    o_alpha,
    output logic                         o_hit
);
    import plcm_pkg::*;

    // Search index width; a single-slot table still gets one index bit
    localparam int IDX_W = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;

    t_cmd             cmd;
    t_sts             sts;
    logic [IDX_W-1:0] idx;

    // Controller: accepts a request only when idle. A write request is stored in the
    // accept cycle. A map request walks the slots from the lowest, skipping empty ones,
    // fetching filled ones and testing the range; the first hit runs the multiply and
    // the divide, a miss goes straight to the result. The result register is loaded only
    // when free, so a pending result holds a map request in its last cycle and keeps the
    // input blocked until the result is taken.
    plcm_ctrl #(
        .SEGMENT_SLOTS (SEGMENT_SLOTS),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .o_idx   (idx),
        .i_sts   (sts)
    );

    // Datapath: segment tables with registered read, valid bits, and four lanes
    // that each interpolate one channel as start +/- |off|*|diff| / |span|.
    plcm_dpath #(
        .SEGMENT_SLOTS (SEGMENT_SLOTS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .IDX_W         (IDX_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_idx         (idx),
        .i_slot        (i_slot),
        .i_start_index (i_start_index),
        .i_end_index   (i_end_index),
        .i_start_color (i_start_color),
        .i_end_color   (i_end_color),
        .i_datum       (i_datum),
        .o_sts         (sts),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_hit         (o_hit)
    );

endmodule

FILE: sv/plcm_ctrl.sv
// Controller of the piecewise-linear color map: request handshake, slot search,
// divide sequencing and result register valid. Depends on plcm_pkg.
module plcm_ctrl #(
    parameter int SEGMENT_SLOTS = 16,
    parameter int IDX_W         = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_mode,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output plcm_pkg::t_cmd     o_cmd,
    output logic [IDX_W-1:0]   o_idx,
    input  plcm_pkg::t_sts     i_sts
);
    import plcm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_hit, n_hit;
    logic             r_out_valid;
    logic             is_last;
    t_cmd             cmd;

    assign is_last = (r_idx == IDX_W'(SEGMENT_SLOTS - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_bit   = r_bit;
        n_hit   = r_hit;
        cmd     = '0;
        cmd.div_bit = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_mode) begin
                        cmd.capture = 1'b1;
                        n_idx   = '0;
                        n_state = S_READ;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (i_sts.slot_valid) begin
                    cmd.read = 1'b1;
                    n_state  = S_CHECK;
                end else if (is_last) begin
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CHECK: begin
                if (i_sts.in_range) begin
                    n_hit   = 1'b1;
                    n_state = S_MUL;
                end else if (is_last) begin
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_bit   = BIT_W'(Q_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.out_hit  = r_hit;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_bit       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bit   <= n_bit;
            r_hit   <= n_hit;
            if (cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;
    assign o_idx   = r_idx;

`ifndef SYNTHESIS
    // A map request starts the slot search on the next cycle
    a_map_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_mode) |=> (r_state == S_READ))
        else $error("map request did not start the search");

    // Never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || i_ready))
        else $error("result register overwritten while pending");

    // The divide runs all its steps before finishing
    a_div_runs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit != '0) |=> (r_state == S_DIV))
        else $error("divide left early");

    // A write request gives no result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_mode && !o_valid) |=> !o_valid)
        else $error("write request produced a result");
`endif

endmodule

FILE: sv/plcm_dpath.sv
// Datapath of the piecewise-linear color map: segment tables, slot valid bits,
// range test, per-channel multiply and restoring divide, result register.
// Depends on plcm_pkg.
module plcm_dpath #(
    parameter int SEGMENT_SLOTS = 16,
    parameter int SAMPLE_BITS   = 10,
    parameter int IDX_W         = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  plcm_pkg::t_cmd                 i_cmd,
    input  logic [IDX_W-1:0]               i_idx,
    input  logic [plcm_pkg::SLOT_W-1:0]    i_slot,
    input  logic [SAMPLE_BITS-1:0]         i_start_index,
    input  logic [SAMPLE_BITS-1:0]         i_end_index,
    input  logic [plcm_pkg::COLOR_W-1:0]   i_start_color,
    input  logic [plcm_pkg::COLOR_W-1:0]   i_end_color,
    input  logic [SAMPLE_BITS-1:0]         i_datum,
    output plcm_pkg::t_sts                 o_sts,
    output logic [plcm_pkg::CH_W-1:0]      o_red,
    output logic [plcm_pkg::CH_W-1:0]      o_green,
    output logic [plcm_pkg::CH_W-1:0]      o_blue,
    output logic [plcm_pkg::CH_W-1:0]      o_alpha,
    output logic                           o_hit
);
    import plcm_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int REM_W = SB + CH_W;

    logic [2*SB-1:0]        r_bound_mem [SEGMENT_SLOTS];
    logic [2*COLOR_W-1:0]   r_color_mem [SEGMENT_SLOTS];
    logic [SEGMENT_SLOTS-1:0] r_valid;

    logic [2*SB-1:0]        r_rd_bound;
    logic [2*COLOR_W-1:0]   r_rd_color;
    logic [SB-1:0]          r_datum;
    logic [SB-1:0]          r_den;
    logic                   r_span_zero;
    logic [REM_W-1:0]       r_rem [CH_NUM];
    logic [Q_W-1:0]         r_q   [CH_NUM];
    logic                   r_neg [CH_NUM];
    t_chan                  r_out_ch [CH_NUM];
    logic                   r_out_hit;

    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [IDX_W-1:0]        wr_idx;
    logic                    slot_ok;
    logic [SB-1:0]           sa, sb, lo, hi;
    logic                    fwd;
    logic [SB-1:0]           off_mag, span_mag;

    assign slot_ext = (IDX_W + SLOT_W)'(i_slot);
    assign wr_idx   = slot_ext[IDX_W-1:0];
    assign slot_ok  = (32'(i_slot) < SEGMENT_SLOTS);

    // Table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && slot_ok) begin
            r_bound_mem[wr_idx] <= {i_start_index, i_end_index};
            r_color_mem[wr_idx] <= {i_start_color, i_end_color};
        end
        if (i_cmd.read) begin
            r_rd_bound <= r_bound_mem[i_idx];
            r_rd_color <= r_color_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write && slot_ok) begin
            r_valid[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_datum <= i_datum;
        end
    end

    // Range test on the fetched segment, bounds in either order
    assign sa  = r_rd_bound[2*SB-1:SB];
    assign sb  = r_rd_bound[SB-1:0];
    assign fwd = (sa <= sb);
    assign lo  = fwd ? sa : sb;
    assign hi  = fwd ? sb : sa;

    // Sample lies between the bounds, so offset and span share a sign
    assign off_mag  = fwd ? (r_datum - sa) : (sa - r_datum);
    assign span_mag = fwd ? (sb - sa) : (sa - sb);

    assign o_sts.slot_valid = r_valid[i_idx];
    assign o_sts.in_range   = (r_datum >= lo) && (r_datum <= hi);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_den       <= span_mag;
            r_span_zero <= (span_mag == '0);
        end
    end

    for (genvar k = 0; k < CH_NUM; k++) begin : g_lane
        t_chan            cs, ce, diff_mag;
        logic             neg;
        logic [REM_W-1:0] trial;

        assign cs       = r_rd_color[2*COLOR_W-1-CH_W*k -: CH_W];
        assign ce       = r_rd_color[COLOR_W-1-CH_W*k -: CH_W];
        assign neg      = (ce < cs);
        assign diff_mag = neg ? (cs - ce) : (ce - cs);
        assign trial    = REM_W'(r_den) << i_cmd.div_bit;

        always_ff @(posedge i_clk) begin
            if (i_cmd.mul) begin
                r_rem[k] <= REM_W'(off_mag) * REM_W'(diff_mag);
                r_neg[k] <= neg;
                r_q[k]   <= '0;
            end else if (i_cmd.div_step) begin
                if (r_rem[k] >= trial) begin
                    r_rem[k]              <= r_rem[k] - trial;
                    r_q[k][i_cmd.div_bit] <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                if (!i_cmd.out_hit) begin
                    r_out_ch[k] <= '0;
                end else if (r_span_zero) begin
                    r_out_ch[k] <= cs;
                end else if (r_neg[k]) begin
                    r_out_ch[k] <= cs - CH_W'(r_q[k]);
                end else begin
                    r_out_ch[k] <= cs + CH_W'(r_q[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit <= i_cmd.out_hit;
        end
    end

    assign o_red   = r_out_ch[0];
    assign o_green = r_out_ch[1];
    assign o_blue  = r_out_ch[2];
    assign o_alpha = r_out_ch[3];
    assign o_hit   = r_out_hit;

endmodule
